// ===== src/assert_macros.svh =====
// Assertion macros used by the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge of clk, also during reset.
`define CHK_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

// Property checked at every rising edge of clk while the reset is low.
`define CHK_ASSERT_RST(lbl, rst_sig, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst_sig) prop) else $error(msg);

`endif

// ===== src/lcdcdb_pkg.sv =====
// Package with types and constants of the LCD column driver bank.
`timescale 1ns / 1ps

package lcdcdb_pkg;

  // Fixed field widths of the request and result.
  localparam int MASK_W    = 3;
  localparam int BYTE_W    = 8;
  localparam int CHIP_W    = 2;
  localparam int PAGE_W    = 2;
  localparam int COL_W     = 6;
  localparam int RAM_AW    = PAGE_W + COL_W;
  localparam int RAM_DEPTH = 1 << RAM_AW;
  // Wide enough to hold any driver count from one to eight.
  localparam int DRV_CNT_W = 4;

  // Request and result packing.
  localparam int IN_DATA_W  = 24;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 16;

  // Command bytes.
  localparam logic [BYTE_W-1:0] CMD_DISP_OFF  = 8'h38;
  localparam logic [BYTE_W-1:0] CMD_DISP_ON   = 8'h39;
  localparam logic [BYTE_W-1:0] CMD_STEP_DOWN = 8'h3A;
  localparam logic [BYTE_W-1:0] CMD_STEP_UP   = 8'h3B;
  localparam logic [COL_W-1:0]  CMD_START_PG  = 6'h3E;

  // Control bundle from the top level to one driver.
  typedef struct packed {
    logic              clr_en;
    logic [RAM_AW-1:0] clr_addr;
    logic              wr_en;
    logic              is_data;
    logic [BYTE_W-1:0] bus_byte;
    logic              rd_en;
    logic [PAGE_W-1:0] page;
    logic [COL_W-1:0]  column;
  } drv_req_t;

endpackage

// ===== src/lcd_column_driver_bank.sv =====
// Top level of the LCD column driver bank: stream ports, clearing pass, output stages.
// A request is taken every cycle when the result side keeps up and no clearing pass runs.
// A fetch result passes the RAM read register and then the output register; bus writes
// give a zero result through the same registers.
// After reset a clearing pass writes zeros to all 256 RAM rows of every driver in
// parallel, one row per cycle; s_axis_tready stays low until the pass ends.
`timescale 1ns / 1ps

module lcd_column_driver_bank
  import lcdcdb_pkg::*;
#(
  parameter int NUM_DRIVERS = 3,
  parameter int COLUMNS     = 50
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // chip_mask[2:0], bus_byte[10:3], fetch_chip[12:11], fetch_page[14:13],
  // fetch_column[20:15], zero fill [23:21]
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // mode[0], is_data[1]
  input  logic [IN_USER_W-1:0]  s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // pixel_byte[7:0], display_on[8], zero fill [15:9]
  output logic [OUT_DATA_W-1:0] m_axis_tdata
);

  logic              clr_active;
  logic [RAM_AW-1:0] clr_addr;
  logic              in_acc;
  logic              s1_valid;
  logic              s1_fetch;
  logic [CHIP_W-1:0] s1_chip;
  logic              s1_adv;
  logic [BYTE_W-1:0] out_pixel;
  logic              out_on;
  logic [BYTE_W-1:0] sel_pixel;
  logic              sel_on;

  logic              mode;
  logic [MASK_W-1:0] chip_mask;
  logic              is_data;
  logic [BYTE_W-1:0] bus_byte;
  logic [CHIP_W-1:0] fetch_chip;
  logic [PAGE_W-1:0] fetch_page;
  logic [COL_W-1:0]  fetch_column;

  drv_req_t          req     [NUM_DRIVERS];
  logic [BYTE_W-1:0] rd_data [NUM_DRIVERS];
  logic              on_flag [NUM_DRIVERS];

  // Unpack the request.
  assign mode         = s_axis_tuser[0];
  assign is_data      = s_axis_tuser[1];
  assign chip_mask    = s_axis_tdata[2:0];
  assign bus_byte     = s_axis_tdata[10:3];
  assign fetch_chip   = s_axis_tdata[12:11];
  assign fetch_page   = s_axis_tdata[14:13];
  assign fetch_column = s_axis_tdata[20:15];

  // Handshake: the read stage moves on when the output register is free or drained.
  assign s1_adv        = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = !clr_active && (!s1_valid || s1_adv);
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  // Clearing pass over all RAM rows after reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_active <= 1'b1;
      clr_addr   <= '0;
    end else if (clr_active) begin
      clr_addr <= clr_addr + RAM_AW'(1);
      if (clr_addr == RAM_AW'(RAM_DEPTH - 1)) begin
        clr_active <= 1'b0;
      end
    end
  end

  // Driver lanes.
  for (genvar d = 0; d < NUM_DRIVERS; d++) begin : g_drv
    logic sel;
    if (d < MASK_W) begin : g_sel
      assign sel = chip_mask[d];
    end else begin : g_nosel
      assign sel = 1'b0;
    end

    always_comb begin
      req[d].clr_en   = clr_active;
      req[d].clr_addr = clr_addr;
      req[d].wr_en    = in_acc && !mode && sel;
      req[d].is_data  = is_data;
      req[d].bus_byte = bus_byte;
      req[d].rd_en    = in_acc && mode;
      req[d].page     = fetch_page;
      req[d].column   = fetch_column;
    end

    lcdcdb_driver #(
      .COLUMNS (COLUMNS)
    ) u_drv (
      .clk     (clk),
      .rst     (rst),
      .req     (req[d]),
      .rd_data (rd_data[d]),
      .on_flag (on_flag[d])
    );
  end

  // Read stage: tracks the request whose RAM read is in flight.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_acc) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_fetch <= mode && (DRV_CNT_W'(fetch_chip) < DRV_CNT_W'(NUM_DRIVERS));
      s1_chip  <= fetch_chip;
    end
  end

  // Pick the fetched driver; writes and absent drivers give zero.
  always_comb begin
    sel_pixel = '0;
    sel_on    = 1'b0;
    for (int d = 0; d < NUM_DRIVERS; d++) begin
      if (s1_fetch && (DRV_CNT_W'(s1_chip) == DRV_CNT_W'(d))) begin
        sel_pixel = rd_data[d];
        sel_on    = on_flag[d];
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (s1_adv) begin
      m_axis_tvalid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_valid) begin
      out_pixel <= sel_pixel;
      out_on    <= sel_on;
    end
  end

  assign m_axis_tdata = {(OUT_DATA_W - BYTE_W - 1)'(0), out_on, out_pixel};

endmodule

// ===== src/lcdcdb_ram.sv =====
// Display RAM of one driver: one write port, one read port with registered data.
`timescale 1ns / 1ps

module lcdcdb_ram
  import lcdcdb_pkg::*;
(
  input  logic              clk,
  input  logic              we,
  input  logic [RAM_AW-1:0] waddr,
  input  logic [BYTE_W-1:0] wdata,
  input  logic              re,
  input  logic [RAM_AW-1:0] raddr,
  output logic [BYTE_W-1:0] rdata
);

  logic [BYTE_W-1:0] mem [RAM_DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port; the data holds while no read is issued.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/lcdcdb_driver.sv =====
// One column driver: address, mode registers and its display RAM.
`timescale 1ns / 1ps

module lcdcdb_driver
  import lcdcdb_pkg::*;
#(
  parameter int COLUMNS = 50
) (
  input  logic              clk,
  input  logic              rst,
  input  drv_req_t          req,
  output logic [BYTE_W-1:0] rd_data,
  output logic              on_flag
);

  logic [RAM_AW-1:0] addr;
  logic [RAM_AW-1:0] addr_next;
  logic              step_down;
  logic              step_down_next;
  logic [PAGE_W-1:0] top_page;
  logic [PAGE_W-1:0] top_page_next;
  logic              on_flag_next;
  logic [COL_W:0]    col_inc;
  logic [COL_W-1:0]  col_step;
  logic              ram_we;
  logic [RAM_AW-1:0] ram_waddr;
  logic [BYTE_W-1:0] ram_wdata;
  logic [RAM_AW-1:0] ram_raddr;

  // Column step after a data write, wrapping at the last column.
  always_comb begin
    col_inc = {1'b0, addr[COL_W-1:0]} + (COL_W+1)'(1);
    if (step_down) begin
      col_step = (addr[COL_W-1:0] == '0) ? COL_W'(COLUMNS - 1)
                                          : addr[COL_W-1:0] - COL_W'(1);
    end else begin
      col_step = (col_inc >= (COL_W+1)'(COLUMNS)) ? '0 : col_inc[COL_W-1:0];
    end
  end

  // Data writes and command decoding.
  always_comb begin
    addr_next      = addr;
    step_down_next = step_down;
    top_page_next  = top_page;
    on_flag_next   = on_flag;
    if (req.wr_en) begin
      if (req.is_data) begin
        addr_next = {addr[RAM_AW-1:COL_W], col_step};
      end else if (req.bus_byte == CMD_DISP_OFF) begin
        on_flag_next = 1'b0;
      end else if (req.bus_byte == CMD_DISP_ON) begin
        on_flag_next = 1'b1;
      end else if (req.bus_byte == CMD_STEP_DOWN) begin
        step_down_next = 1'b1;
      end else if (req.bus_byte == CMD_STEP_UP) begin
        step_down_next = 1'b0;
      end else if (req.bus_byte[COL_W-1:0] == CMD_START_PG) begin
        top_page_next = req.bus_byte[BYTE_W-1:COL_W];
      end else if ({1'b0, req.bus_byte[COL_W-1:0]} < (COL_W+1)'(COLUMNS)) begin
        addr_next = req.bus_byte;
      end
    end
  end

  // Driver registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      addr      <= '0;
      step_down <= 1'b0;
      top_page  <= '0;
      on_flag   <= 1'b0;
    end else begin
      addr      <= addr_next;
      step_down <= step_down_next;
      top_page  <= top_page_next;
      on_flag   <= on_flag_next;
    end
  end

  // RAM port selection: the clearing pass takes the write port after reset.
  assign ram_we    = req.clr_en | (req.wr_en & req.is_data);
  assign ram_waddr = req.clr_en ? req.clr_addr : addr;
  assign ram_wdata = req.clr_en ? '0 : req.bus_byte;
  assign ram_raddr = {top_page + req.page, req.column};

  lcdcdb_ram u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (req.rd_en),
    .raddr (ram_raddr),
    .rdata (rd_data)
  );

endmodule

// ===== src/lcdcdb_checker.sv =====
// Port-level checker for the LCD column driver bank, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lcdcdb_checker
  import lcdcdb_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  s_axis_tready,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata
);

  // No result is offered in the cycle after reset.
  `CHK_ASSERT(a_no_out_after_rst, rst |=> !m_axis_tvalid, "result valid after reset")

  // The clearing pass holds off requests right after reset.
  `CHK_ASSERT(a_busy_after_rst, rst |=> !s_axis_tready, "request taken during RAM clear")

  // The fill bits above the display flag are always zero.
  `CHK_ASSERT_RST(a_out_fill, rst, m_axis_tvalid |-> (m_axis_tdata[15:9] == 7'd0),
    "non-zero fill bits in result")

  // A stalled result keeps its value.
  `CHK_ASSERT_RST(a_out_hold, rst,
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)),
    "stalled result changed")

endmodule

bind lcd_column_driver_bank lcdcdb_checker u_chk (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// ===== bench/tb.sv =====
// Self-checking testbench for the LCD column driver bank: stream stimulus, scoreboard, checks.
`timescale 1ns / 1ps

module tb;
  import lcdcdb_pkg::*;

  localparam int NUM_DRIVERS = 3;
  localparam int COLUMNS     = 50;

  // One request as the bench sees it, before packing onto the stream.
  typedef struct packed {
    logic       mode;
    logic [2:0] chip_mask;
    logic       is_data;
    logic [7:0] bus_byte;
    logic [1:0] fetch_chip;
    logic [1:0] fetch_page;
    logic [5:0] fetch_column;
  } bank_request_t;

  // One expected result of a request.
  typedef struct packed {
    logic [7:0] pixel_byte;
    logic       display_on;
  } pixel_result_t;

  // Keeps its own copy of every driver's RAM and registers and the queue of
  // results still owed by the block.
  class lcd_bank_scoreboard;
    logic [7:0]    ram [NUM_DRIVERS][lcdcdb_pkg::RAM_DEPTH];
    logic [7:0]    address [NUM_DRIVERS];
    logic          step_dn [NUM_DRIVERS];
    logic [1:0]    start_pg [NUM_DRIVERS];
    logic          lit [NUM_DRIVERS];
    pixel_result_t owed_q[$];
    int            errors;
    int            writes;
    int            fetches;
    int            absent_fetches;
    int            results;

    function new();
      for (int d = 0; d < NUM_DRIVERS; d++) begin
        for (int a = 0; a < lcdcdb_pkg::RAM_DEPTH; a++) ram[d][a] = 8'h00;
        address[d]  = 8'h00;
        step_dn[d]  = 1'b0;
        start_pg[d] = 2'd0;
        lit[d]      = 1'b0;
      end
      errors = 0;
      writes = 0;
      fetches = 0;
      absent_fetches = 0;
      results = 0;
    endfunction

    // Applies one bus byte to one driver: a data store with column step, or a command.
    function void apply_bus_byte(int d, logic is_data, logic [7:0] b);
      logic [7:0] a;
      int         col;
      if (is_data) begin
        a = address[d];
        col = a[5:0];
        ram[d][a] = b;
        if (step_dn[d]) begin
          col = (col == 0) ? COLUMNS - 1 : col - 1;
        end else begin
          col = (col + 1 >= COLUMNS) ? 0 : col + 1;
        end
        address[d] = {a[7:6], 6'(col)};
      end else if (b == lcdcdb_pkg::CMD_DISP_OFF) begin
        lit[d] = 1'b0;
      end else if (b == lcdcdb_pkg::CMD_DISP_ON) begin
        lit[d] = 1'b1;
      end else if (b == lcdcdb_pkg::CMD_STEP_DOWN) begin
        step_dn[d] = 1'b1;
      end else if (b == lcdcdb_pkg::CMD_STEP_UP) begin
        step_dn[d] = 1'b0;
      end else if (b[5:0] == lcdcdb_pkg::CMD_START_PG) begin
        start_pg[d] = b[7:6];
      end else if (int'(b[5:0]) < COLUMNS) begin
        address[d] = b;
      end
    endfunction

    // Notes an accepted request and queues the result it must produce.
    function void note_request(bank_request_t req);
      pixel_result_t res;
      logic [1:0]    row;
      res = '0;
      if (!req.mode) begin
        writes++;
        for (int d = 0; d < NUM_DRIVERS && d < 3; d++) begin
          if (req.chip_mask[d]) apply_bus_byte(d, req.is_data, req.bus_byte);
        end
      end else begin
        fetches++;
        if (int'(req.fetch_chip) < NUM_DRIVERS) begin
          row = start_pg[req.fetch_chip] + req.fetch_page;
          res.pixel_byte = ram[req.fetch_chip][{row, req.fetch_column}];
          res.display_on = lit[req.fetch_chip];
        end else begin
          absent_fetches++;
        end
      end
      owed_q.push_back(res);
    endfunction

    task report(string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      errors++;
    endtask

    // Compares one accepted result with the oldest one owed.
    task check_result(logic [15:0] data);
      pixel_result_t want;
      if (owed_q.size() == 0) begin
        report($sformatf("result 0x%04h with nothing owed", data));
      end else begin
        want = owed_q.pop_front();
        results++;
        if (data[7:0] !== want.pixel_byte)
          report($sformatf("pixel_byte 0x%02h, wanted 0x%02h", data[7:0], want.pixel_byte));
        if (data[8] !== want.display_on)
          report($sformatf("display_on %b, wanted %b", data[8], want.display_on));
      end
    endtask

    function int pending();
      return owed_q.size();
    endfunction
  endclass

  logic                  clk;
  logic                  rst;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  // chip_mask, bus_byte, fetch_chip, fetch_page, fetch_column, zero fill
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  // mode, is_data
  logic [IN_USER_W-1:0]  s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  // pixel_byte, display_on, zero fill
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  int send_idle;
  int recv_idle;
  int hold_left;

  lcd_bank_scoreboard sb = new();

  lcd_column_driver_bank #(
    .NUM_DRIVERS(NUM_DRIVERS),
    .COLUMNS    (COLUMNS)
  ) u_top (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  // Clock with a 20 ns period.
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Overall time limit; covers the clearing pass, the hold-off and heavy idling.
  initial begin
    #4_000_000;
    $display("Timeout with %0d results still owed", sb.pending());
    $display("CHECK FAILED");
    $finish;
  end

  // Receiver: random idling, or a long hold-off counted down here.
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        m_axis_tready = 1'b0;
        hold_left = hold_left - 1;
      end else begin
        m_axis_tready = ($urandom_range(0, 99) >= recv_idle);
      end
    end
  end

  // Result monitor.
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
  end

  // Offers one request, with random idle cycles first, and returns at the
  // falling edge after it has been taken.
  task automatic send_request(input bank_request_t req);
    while ($urandom_range(0, 99) < send_idle) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {3'b000, req.fetch_column, req.fetch_page, req.fetch_chip,
                     req.bus_byte, req.chip_mask};
    s_axis_tuser  = {req.is_data, req.mode};
    do @(posedge clk); while (!s_axis_tready);
    sb.note_request(req);
    @(negedge clk);
  endtask

  // Stops offering and waits until every owed result has come back.
  task automatic drain_results();
    s_axis_tvalid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // A bus write; the fetch fields carry random filler.
  function automatic bank_request_t bus_write(logic [2:0] mask, logic is_data, logic [7:0] b);
    bank_request_t req;
    req = bank_request_t'($urandom);
    req.mode      = 1'b0;
    req.chip_mask = mask;
    req.is_data   = is_data;
    req.bus_byte  = b;
    return req;
  endfunction

  // A display fetch; the bus fields carry random filler.
  function automatic bank_request_t fetch(logic [1:0] chip, logic [1:0] page, logic [5:0] col);
    bank_request_t req;
    req = bank_request_t'($urandom);
    req.mode         = 1'b1;
    req.fetch_chip   = chip;
    req.fetch_page   = page;
    req.fetch_column = col;
    return req;
  endfunction

  // Mostly a valid column; now and then one at or above the column count.
  function automatic logic [5:0] pick_column();
    if ($urandom_range(0, 99) < 88) return 6'($urandom_range(0, COLUMNS - 1));
    return 6'($urandom_range(COLUMNS, 63));
  endfunction

  // A command byte spread over every kind of command.
  function automatic logic [7:0] pick_command();
    logic [5:0] col;
    case ($urandom_range(0, 7))
      0: return CMD_DISP_OFF;
      1: return CMD_DISP_ON;
      2: return CMD_STEP_DOWN;
      3: return CMD_STEP_UP;
      4: return {2'($urandom), CMD_START_PG};
      5: return {2'($urandom), 6'($urandom_range(0, COLUMNS - 1))};
      6: begin
        // Address with an out-of-range column, which must be ignored.
        col = 6'($urandom_range(COLUMNS, 63));
        if (col == CMD_START_PG) col = 6'd63;
        return {2'($urandom), col};
      end
      default: return 8'($urandom);
    endcase
  endfunction

  // Random traffic, mostly address-then-data bursts and fetch bursts.
  task automatic random_traffic(input int count);
    int         sent;
    int         len;
    logic [2:0] mask;
    logic [1:0] chip;
    logic [1:0] page;
    logic [5:0] col;
    sent = 0;
    while (sent < count) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          // Maybe set a direction, then an address, then a run of data bytes.
          mask = ($urandom_range(0, 19) == 0) ? 3'd0 : 3'($urandom_range(1, 7));
          if ($urandom_range(0, 2) == 0) begin
            send_request(bus_write(mask, 1'b0,
                         $urandom_range(0, 1) ? CMD_STEP_DOWN : CMD_STEP_UP));
            sent++;
          end
          send_request(bus_write(mask, 1'b0,
                       {2'($urandom), 6'($urandom_range(0, COLUMNS - 1))}));
          len = $urandom_range(1, 12);
          for (int i = 0; i < len; i++) send_request(bus_write(mask, 1'b1, 8'($urandom)));
          sent += len + 1;
        end
        4, 5, 6: begin
          // Scan along a row of one driver, occasionally an absent one.
          chip = ($urandom_range(0, 9) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
          page = 2'($urandom);
          col  = pick_column();
          len  = $urandom_range(1, 10);
          for (int i = 0; i < len; i++) begin
            send_request(fetch(chip, page, col));
            col = 6'(col + 1);
          end
          sent += len;
        end
        7, 8: begin
          send_request(bus_write(3'($urandom), 1'b0, pick_command()));
          sent++;
        end
        default: begin
          // Noise: every field random.
          send_request(bank_request_t'($urandom));
          sent++;
        end
      endcase
    end
  endtask

  // Main sequence.
  initial begin
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    send_idle = 0;
    recv_idle = 0;
    hold_left = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed requests: reset contents, column wrap both ways, start page,
    // ignored addresses, absent driver, empty mask and high columns.
    send_request(fetch(2'd0, 2'd0, 6'd0));
    send_request(bus_write(3'd7, 1'b0, CMD_DISP_ON));
    send_request(bus_write(3'd1, 1'b0, 8'h00));
    send_request(bus_write(3'd1, 1'b1, 8'hFF));
    send_request(bus_write(3'd1, 1'b1, 8'h00));
    send_request(fetch(2'd0, 2'd0, 6'd0));
    send_request(bus_write(3'd2, 1'b0, CMD_STEP_DOWN));
    send_request(bus_write(3'd2, 1'b0, 8'h40));
    send_request(bus_write(3'd2, 1'b1, 8'hA5));
    send_request(bus_write(3'd2, 1'b1, 8'h5A));
    send_request(fetch(2'd1, 2'd1, 6'd49));
    send_request(bus_write(3'd4, 1'b0, 8'hF1));
    send_request(bus_write(3'd4, 1'b1, 8'h81));
    send_request(bus_write(3'd4, 1'b1, 8'h7E));
    send_request(bus_write(3'd2, 1'b0, 8'hFE));
    send_request(fetch(2'd1, 2'd2, 6'd0));
    send_request(bus_write(3'd7, 1'b0, 8'h32));
    send_request(bus_write(3'd7, 1'b0, 8'h3F));
    send_request(bus_write(3'd1, 1'b1, 8'h11));
    send_request(fetch(2'd3, 2'd3, 6'd63));
    send_request(fetch(2'd2, 2'd3, 6'd63));
    send_request(bus_write(3'd0, 1'b1, 8'hEE));
    send_request(bus_write(3'd1, 1'b0, CMD_DISP_OFF));
    send_request(fetch(2'd0, 2'd0, 6'd2));
    send_request(bus_write(3'd2, 1'b0, CMD_STEP_UP));
    drain_results();

    // Sender lightly idle, receiver mostly stalled.
    send_idle = 24;
    recv_idle = 81;
    random_traffic(230);

    // Long receiver hold-off while requests keep coming, so the block backs up.
    send_idle = 0;
    hold_left = 300;
    random_traffic(40);
    drain_results();

    // Sender mostly idle, receiver lightly stalled.
    send_idle = 81;
    recv_idle = 24;
    random_traffic(230);

    // No idling on either side.
    send_idle = 0;
    recv_idle = 0;
    random_traffic(230);

    drain_results();
    repeat (8) @(posedge clk);

    $display("Run covered %0d bus writes and %0d fetches (%0d from an absent driver).",
             sb.writes, sb.fetches, sb.absent_fetches);
    $display("%0d results checked under three idling patterns and a long output stall.",
             sb.results);
    if (sb.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
+incdir+src
src/lcdcdb_pkg.sv
src/lcdcdb_ram.sv
src/lcdcdb_driver.sv
src/lcd_column_driver_bank.sv
src/lcdcdb_checker.sv
bench/tb.sv
